[sv/sws_pkg.sv]
package sws_pkg;

  localparam int unsigned RETX_DEPTH_DEF = 16;

  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [7:0]  DUP_LIMIT = 8'd3;
  localparam logic [7:0]  DUP_MAX   = 8'd255;

  // connection states
  localparam logic [1:0] CONN_CLOSED   = 2'd0;
  localparam logic [1:0] CONN_SYN_SENT = 2'd1;
  localparam logic [1:0] CONN_EST      = 2'd2;
  localparam logic [1:0] CONN_FIN_WAIT = 2'd3;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_RX    = 2'd1;

  // register indexes
  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_SEGMENT = 3'd1;
  localparam logic [2:0] REG_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_DATA    = 3'd3;
  localparam logic [2:0] REG_DROP    = 3'd4;
  localparam logic [2:0] REG_SEED    = 3'd5;
  localparam logic [2:0] REG_ISEQ    = 3'd6;

  localparam logic [15:0] WINDOW_RST  = 16'd4096;
  localparam logic [11:0] SEGMENT_RST = 12'd512;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [23:0] DATA_RST    = 24'd0;
  localparam logic [15:0] DROP_RST    = 16'd0;
  localparam logic [15:0] SEED_RST    = 16'd1;
  localparam logic [31:0] ISEQ_RST    = 32'd121;

  typedef struct packed {
    logic [31:0] seq;
    logic [11:0] len;
    logic [31:0] tim;
  } entry_t;

  typedef struct packed {
    logic        done;
    logic        retx;
    logic        dropped;
    logic [23:0] offset;
    logic [11:0] len;
    logic        fin;
    logic        ackf;
    logic        syn;
    logic [31:0] ack;
    logic [31:0] seq;
  } res_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    logic [15:0] y;
    y = x >> 1;
    if (x[0]) begin
      y = y ^ LFSR_MASK;
    end
    return y;
  endfunction

endpackage

[sv/sws_ram.sv]
module sws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sliding_window_sender_unit.sv]
// Channel | Dir | Group                              | Word
// in_     | in  | in_tvalid/in_tready/in_tdata/tuser | one event (start, segment received, poll)
// out_    | out | out_tvalid/out_tready/out_tdata    | one outgoing segment, tlast on last of event
// cfg_    | in  | APB psel/penable/pwrite/paddr      | seven 32-bit registers at 4*index
//
// One event at a time; in_tready is high only while idle. A closed, FIN-wait or unanswered
// handshake event runs accept, dispatch and flush; a completed handshake goes on to the data
// phase. A data-phase event runs dispatch, FIN check (straight to flush if FIN goes out), new
// send and ack update, then passes through the single table RAM, each entry read in one phase
// and handled in the next: an optional duplicate-ACK search and shift, then two walk passes,
// then FIN check and flush.
// rst_n clears all control state; the table needs no clearing (entry count is zero).
// A stalled out_tready holds the sequencer at the next segment it would send.
module sliding_window_sender_unit #(
  parameter int unsigned RETX_DEPTH = sws_pkg::RETX_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // now_ms, rx_seq, rx_ack, rx_syn, rx_ack_flag, rx_fin
  input  logic [1:0]   in_tuser,  // action
  output logic         out_tvalid,
  input  logic         out_tready,
  // tx_seq, tx_ack, tx_syn, tx_ack_flag, tx_fin, tx_length, tx_offset,
  // tx_dropped, tx_retransmit, connection_done
  output logic [111:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int unsigned IW = $clog2(RETX_DEPTH);
  localparam int unsigned CW = $clog2(RETX_DEPTH + 1);
  localparam int unsigned AW = IW + 1;
  localparam int unsigned EW = $bits(sws_pkg::entry_t);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DP    = 4'd2;
  localparam logic [3:0] S_NEW   = 4'd3;
  localparam logic [3:0] S_RX    = 4'd4;
  localparam logic [3:0] S_FS    = 4'd5;
  localparam logic [3:0] S_SH    = 4'd6;
  localparam logic [3:0] S_SHL   = 4'd7;
  localparam logic [3:0] S_W1    = 4'd8;
  localparam logic [3:0] S_W2    = 4'd9;
  localparam logic [3:0] S_WEND  = 4'd10;
  localparam logic [3:0] S_FLUSH = 4'd11;

  // configuration
  logic [15:0] win_r, tmo_r, thr_r, seed_r;
  logic [11:0] seg_r;
  logic [23:0] dbytes_r;
  logic [31:0] iseq_r;
  logic        cfg_wr;

  // connection state
  logic [1:0]    conn_r;
  logic [31:0]   next_seq_r, peer_r, ha_r, base_r;
  logic [7:0]    dup_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   lfsr_r;
  logic          bank_r;

  // latched event
  logic [1:0]  act_r;
  logic [31:0] now_r, rseq_r, rack_r;
  logic        rsyn_r, rackf_r, rfin_r, has_rx_r;

  // sequencer
  logic [3:0]       st_r, st_nxt;
  logic             ph_r;
  logic [CW-1:0]    i_r, na_r, wi_r;
  logic [11:0]      len_r;
  logic             elig_r;
  sws_pkg::entry_t  sv_r;

  // result staging
  logic            pend_v_r, out_v_r, out_last_r;
  sws_pkg::res_t   pend_r, out_r;

  logic            em_req, emit_ok, fire, out_free, flush_go;
  sws_pkg::res_t   em_res;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  sws_pkg::entry_t wdata, rd;
  logic [EW-1:0]   rdata_raw;

  logic [31:0]   end_seq, rem;
  logic [15:0]   lfsr_n;
  logic          rd_acked, rd_tout, fin_due, in_fire;
  logic [32:0]   span;
  logic [CW-1:0] i_inc;
  logic [7:0]    dup_n;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= sws_pkg::WINDOW_RST;
      seg_r    <= sws_pkg::SEGMENT_RST;
      tmo_r    <= sws_pkg::TIMEOUT_RST;
      dbytes_r <= sws_pkg::DATA_RST;
      thr_r    <= sws_pkg::DROP_RST;
      seed_r   <= sws_pkg::SEED_RST;
      iseq_r   <= sws_pkg::ISEQ_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        sws_pkg::REG_WINDOW:  win_r    <= cfg_pwdata[15:0];
        sws_pkg::REG_SEGMENT: seg_r    <= cfg_pwdata[11:0];
        sws_pkg::REG_TIMEOUT: tmo_r    <= cfg_pwdata[15:0];
        sws_pkg::REG_DATA:    dbytes_r <= cfg_pwdata[23:0];
        sws_pkg::REG_DROP:    thr_r    <= cfg_pwdata[15:0];
        sws_pkg::REG_SEED:    seed_r   <= cfg_pwdata[15:0];
        sws_pkg::REG_ISEQ:    iseq_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      sws_pkg::REG_WINDOW:  cfg_prdata = {16'd0, win_r};
      sws_pkg::REG_SEGMENT: cfg_prdata = {20'd0, seg_r};
      sws_pkg::REG_TIMEOUT: cfg_prdata = {16'd0, tmo_r};
      sws_pkg::REG_DATA:    cfg_prdata = {8'd0, dbytes_r};
      sws_pkg::REG_DROP:    cfg_prdata = {16'd0, thr_r};
      sws_pkg::REG_SEED:    cfg_prdata = {16'd0, seed_r};
      sws_pkg::REG_ISEQ:    cfg_prdata = iseq_r;
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // table: two banks of 2**IW entries (RETX_DEPTH rounded up to a power of two), bank_r selects the live one
  sws_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );
  assign rd = sws_pkg::entry_t'(rdata_raw);

  assign end_seq  = base_r + {8'd0, dbytes_r};
  assign rem      = end_seq - next_seq_r;
  assign span     = {21'd0, len_r} + {1'b0, next_seq_r - ha_r};
  assign lfsr_n   = sws_pkg::lfsr_step(lfsr_r);
  assign rd_acked = rd.seq < ha_r;
  assign rd_tout  = (now_r - rd.tim) >= {16'd0, tmo_r};
  assign fin_due  = ha_r >= end_seq;
  assign i_inc    = i_r + CW'(1);
  assign dup_n    = (dup_r == sws_pkg::DUP_MAX) ? dup_r : dup_r + 8'd1;

  assign out_free = !out_v_r || out_tready;
  assign emit_ok  = !pend_v_r || out_free;
  assign fire     = em_req && emit_ok;
  assign flush_go = (st_r == S_FLUSH) && pend_v_r && out_free;
  assign in_tready = (st_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;

  always_comb begin
    case (st_r)
      S_SH:    raddr = {bank_r, i_inc[IW-1:0]};
      default: raddr = {bank_r, i_r[IW-1:0]};
    endcase
  end

  // emit requests and table writes
  always_comb begin
    em_req = 1'b0;
    em_res = '0;
    em_res.ack = peer_r;
    we     = 1'b0;
    waddr  = {bank_r, cnt_r[IW-1:0]};
    wdata  = '{seq: next_seq_r, len: len_r, tim: now_r};
    case (st_r)
      S_DISP: begin
        if (act_r == sws_pkg::ACT_START && conn_r == sws_pkg::CONN_CLOSED) begin
          em_req     = 1'b1;
          em_res.seq = iseq_r;
          em_res.ack = 32'd0;
          em_res.syn = 1'b1;
        end else if (conn_r == sws_pkg::CONN_SYN_SENT) begin
          em_req      = act_r == sws_pkg::ACT_RX && rsyn_r && rackf_r && rack_r == next_seq_r;
          em_res.seq  = next_seq_r;
          em_res.ack  = rseq_r + 32'd1;
          em_res.ackf = 1'b1;
        end else if (conn_r == sws_pkg::CONN_FIN_WAIT) begin
          em_req      = act_r == sws_pkg::ACT_RX && rfin_r && rackf_r && rack_r == next_seq_r;
          em_res.seq  = next_seq_r;
          em_res.ack  = peer_r + 32'd1;
          em_res.ackf = 1'b1;
          em_res.done = 1'b1;
        end
      end
      S_DP, S_WEND: begin
        em_req     = fin_due;
        em_res.seq = next_seq_r;
        em_res.fin = 1'b1;
      end
      S_NEW: begin
        em_req         = elig_r && len_r != 12'd0 && span <= {17'd0, win_r};
        em_res.seq     = next_seq_r;
        em_res.ackf    = 1'b1;
        em_res.len     = len_r;
        em_res.offset  = 24'(next_seq_r - base_r);
        em_res.dropped = lfsr_n < thr_r;
        we             = fire;
      end
      S_FS, S_W1: begin
        if (ph_r && i_r < cnt_r) begin
          if (st_r == S_FS) begin
            em_req = rd.seq == ha_r;
          end else begin
            em_req = !rd_acked && rd_tout;
            we     = !rd_acked && !rd_tout;
            waddr  = {!bank_r, na_r[IW-1:0]};
            wdata  = rd;
          end
          em_res.seq     = rd.seq;
          em_res.ackf    = 1'b1;
          em_res.len     = rd.len;
          em_res.offset  = 24'(rd.seq - base_r);
          em_res.dropped = lfsr_n < thr_r;
          em_res.retx    = 1'b1;
        end
      end
      S_SH: begin
        we    = ph_r && (i_inc < cnt_r);
        waddr = {bank_r, i_r[IW-1:0]};
        wdata = rd;
      end
      S_SHL: begin
        we    = 1'b1;
        waddr = {bank_r, IW'(cnt_r - CW'(1))};
        wdata = '{seq: sv_r.seq, len: sv_r.len, tim: now_r};
      end
      S_W2: begin
        we    = ph_r && (i_r < cnt_r) && !rd_acked && rd_tout;
        waddr = {!bank_r, wi_r[IW-1:0]};
        wdata = '{seq: rd.seq, len: rd.len, tim: now_r};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_fire) st_nxt = S_DISP;
      S_DISP: begin
        if (act_r == sws_pkg::ACT_START && conn_r == sws_pkg::CONN_CLOSED) begin
          if (fire) st_nxt = S_FLUSH;
        end else if (conn_r == sws_pkg::CONN_SYN_SENT) begin
          if (!em_req) st_nxt = S_FLUSH;
          else if (fire) st_nxt = S_DP;
        end else if (conn_r == sws_pkg::CONN_EST) begin
          st_nxt = S_DP;
        end else if (conn_r == sws_pkg::CONN_FIN_WAIT) begin
          if (!em_req || fire) st_nxt = S_FLUSH;
        end else begin
          st_nxt = S_FLUSH;
        end
      end
      S_DP: begin
        if (!fin_due) st_nxt = S_NEW;
        else if (fire) st_nxt = S_FLUSH;
      end
      S_NEW:  if (!em_req || fire) st_nxt = S_RX;
      S_RX: begin
        if (has_rx_r && rack_r == ha_r && dup_n >= sws_pkg::DUP_LIMIT) st_nxt = S_FS;
        else st_nxt = S_W1;
      end
      S_FS: begin
        if (i_r >= cnt_r) st_nxt = S_W1;
        else if (fire) st_nxt = S_SH;
      end
      S_SH:   if (i_inc >= cnt_r) st_nxt = S_SHL;
      S_SHL:  st_nxt = S_W1;
      S_W1:   if (i_r >= cnt_r) st_nxt = S_W2;
      S_W2:   if (i_r >= cnt_r) st_nxt = S_WEND;
      S_WEND: if (!em_req || fire) st_nxt = S_FLUSH;
      S_FLUSH: if (!pend_v_r || out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      conn_r     <= sws_pkg::CONN_CLOSED;
      next_seq_r <= '0;
      peer_r     <= '0;
      ha_r       <= '0;
      base_r     <= '0;
      dup_r      <= '0;
      cnt_r      <= '0;
      lfsr_r     <= 16'd1;
      bank_r     <= 1'b0;
      ph_r       <= 1'b0;
      i_r        <= '0;
      na_r       <= '0;
      wi_r       <= '0;
      has_rx_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (fire && (em_res.ackf && em_res.len != 12'd0)) begin
        lfsr_r <= lfsr_n;
      end
      case (st_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r   <= in_tuser;
            now_r   <= in_tdata[31:0];
            rseq_r  <= in_tdata[63:32];
            rack_r  <= in_tdata[95:64];
            rsyn_r  <= in_tdata[96];
            rackf_r <= in_tdata[97];
            rfin_r  <= in_tdata[98];
          end
        end
        S_DISP: begin
          has_rx_r <= (conn_r == sws_pkg::CONN_EST) && (act_r == sws_pkg::ACT_RX);
          if (act_r == sws_pkg::ACT_START && conn_r == sws_pkg::CONN_CLOSED) begin
            if (fire) begin
              lfsr_r     <= (seed_r != 16'd0) ? seed_r : 16'd1;
              next_seq_r <= iseq_r + 32'd1;
              peer_r     <= '0;
              ha_r       <= '0;
              base_r     <= '0;
              dup_r      <= '0;
              cnt_r      <= '0;
              conn_r     <= sws_pkg::CONN_SYN_SENT;
            end
          end else if (conn_r == sws_pkg::CONN_SYN_SENT) begin
            if (fire) begin
              peer_r <= rseq_r + 32'd1;
              ha_r   <= rack_r;
              base_r <= next_seq_r;
              dup_r  <= '0;
              cnt_r  <= '0;
              conn_r <= sws_pkg::CONN_EST;
            end
          end else if (conn_r == sws_pkg::CONN_FIN_WAIT) begin
            if (fire) begin
              peer_r <= peer_r + 32'd1;
              conn_r <= sws_pkg::CONN_CLOSED;
            end
          end
        end
        S_DP: begin
          len_r  <= (rem > {20'd0, seg_r}) ? seg_r : rem[11:0];
          elig_r <= (next_seq_r < end_seq) && (cnt_r < CW'(RETX_DEPTH));
          if (fire) begin
            next_seq_r <= next_seq_r + 32'd1;
            conn_r     <= sws_pkg::CONN_FIN_WAIT;
          end
        end
        S_NEW: begin
          if (fire) begin
            cnt_r      <= cnt_r + CW'(1);
            next_seq_r <= next_seq_r + {20'd0, len_r};
          end
        end
        S_RX: begin
          i_r  <= '0;
          ph_r <= 1'b0;
          na_r <= '0;
          if (has_rx_r) begin
            if (rack_r > ha_r) begin
              ha_r  <= rack_r;
              dup_r <= 8'd1;
            end else if (rack_r == ha_r) begin
              dup_r <= dup_n;
            end
          end
        end
        S_FS: begin
          if (i_r >= cnt_r) begin
            i_r  <= '0;
            ph_r <= 1'b0;
          end else if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (em_req) begin
            // hold the matching entry for its move to the end
            if (fire) begin
              sv_r <= rd;
              ph_r <= 1'b0;
            end
          end else begin
            i_r  <= i_inc;
            ph_r <= 1'b0;
          end
        end
        S_SH: begin
          if (i_inc < cnt_r) begin
            if (!ph_r) begin
              ph_r <= 1'b1;
            end else begin
              i_r  <= i_inc;
              ph_r <= 1'b0;
            end
          end
        end
        S_SHL: begin
          i_r  <= '0;
          ph_r <= 1'b0;
        end
        S_W1: begin
          if (i_r >= cnt_r) begin
            i_r  <= '0;
            ph_r <= 1'b0;
            wi_r <= na_r;
          end else if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (!em_req || fire) begin
            if (we) na_r <= na_r + CW'(1);
            i_r  <= i_inc;
            ph_r <= 1'b0;
          end
        end
        S_W2: begin
          if (i_r >= cnt_r) begin
            cnt_r  <= wi_r;
            bank_r <= !bank_r;
          end else if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            if (we) wi_r <= wi_r + CW'(1);
            i_r  <= i_inc;
            ph_r <= 1'b0;
          end
        end
        S_WEND: begin
          if (fire) begin
            next_seq_r <= next_seq_r + 32'd1;
            conn_r     <= sws_pkg::CONN_FIN_WAIT;
          end
        end
        default: ;
      endcase
    end
  end

  // one word held back so the last of an event can carry tlast
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (fire) begin
      pend_v_r <= 1'b1;
      if (pend_v_r) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end else if (flush_go) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_r <= em_res;
      if (pend_v_r) begin
        out_r      <= pend_r;
        out_last_r <= 1'b0;
      end
    end else if (flush_go) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_r.done, out_r.retx, out_r.dropped, out_r.offset,
                       out_r.len, out_r.fin, out_r.ackf, out_r.syn, out_r.ack, out_r.seq};

endmodule
